@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when cond holds, expr must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/core/rk8_pkg.sv @@
// ----------------------------------------------------------------------------
// rk8_pkg
// Types, tableau constants and saturation helper for the RK8 stage combiner.
// ----------------------------------------------------------------------------
package rk8_pkg;

    localparam int MAX_DIM     = 64;
    localparam int ADDR_W      = 6;
    localparam int DIM_W       = 7;
    localparam int DATA_W      = 48;
    localparam int FRAC_BITS   = 32;
    localparam int STAGE_W     = 4;
    localparam int NUM_ROWS    = 10;
    localparam int SLOPE_DEPTH = 9 * MAX_DIM;
    localparam int SLOPE_AW    = 10;
    localparam int PROD_W      = 60;
    localparam int ACC_W       = 64;
    localparam int CFG_IDX_W   = 1;

    localparam logic [STAGE_W-1:0] STAGE_FIRST = 4'd1;
    localparam logic [STAGE_W-1:0] STAGE_LAST  = 4'd10;
    localparam logic [STAGE_W-1:0] ROW_LAST_STORED = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b1;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        MSEL_K = 2'd0,
        MSEL_H = 2'd1,
        MSEL_T = 2'd2
    } msel_t;

    typedef struct packed {
        logic  capture;
        logic  load_commit;
        logic  slope_issue;
        logic  rd_issue;
        logic  mul_go;
        msel_t mul_sel;
        logic  acc_add;
        logic  take_d;
        logic  fin_commit;
    } cmd_t;

    typedef struct packed {
        logic in_load;
        logic j_last;
        logic mul_done;
        logic out_free;
    } sts_t;

    // Tableau a/b coefficients, Q.FRAC_BITS, rounded to nearest.
    localparam data_t COEF_K [NUM_ROWS][NUM_ROWS] = '{
        '{48'((64'sd4*ONE+64'sd13)/64'sd27), 48'sd0, 48'sd0, 48'sd0, 48'sd0,
          48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
        '{48'((64'sd1*ONE+64'sd9)/64'sd18), 48'((64'sd3*ONE+64'sd9)/64'sd18),
          48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
        '{48'((64'sd1*ONE+64'sd6)/64'sd12), 48'sd0, 48'((64'sd3*ONE+64'sd6)/64'sd12),
          48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
        '{48'((64'sd1*ONE+64'sd4)/64'sd8), 48'sd0, 48'sd0,
          48'((64'sd3*ONE+64'sd4)/64'sd8), 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
        '{48'((64'sd13*ONE+64'sd27)/64'sd54), 48'sd0,
          48'(-((64'sd27*ONE+64'sd27)/64'sd54)),
          48'((64'sd42*ONE+64'sd27)/64'sd54),
          48'((64'sd8*ONE+64'sd27)/64'sd54), 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
        '{48'((64'sd389*ONE+64'sd2160)/64'sd4320), 48'sd0,
          48'(-((64'sd54*ONE+64'sd2160)/64'sd4320)),
          48'((64'sd966*ONE+64'sd2160)/64'sd4320),
          48'(-((64'sd824*ONE+64'sd2160)/64'sd4320)),
          48'((64'sd243*ONE+64'sd2160)/64'sd4320), 48'sd0, 48'sd0, 48'sd0, 48'sd0},
        '{48'(-((64'sd231*ONE+64'sd10)/64'sd20)), 48'sd0,
          48'((64'sd81*ONE+64'sd10)/64'sd20),
          48'(-((64'sd1164*ONE+64'sd10)/64'sd20)),
          48'((64'sd656*ONE+64'sd10)/64'sd20),
          48'(-((64'sd122*ONE+64'sd10)/64'sd20)),
          48'((64'sd800*ONE+64'sd10)/64'sd20), 48'sd0, 48'sd0, 48'sd0},
        '{48'(-((64'sd127*ONE+64'sd144)/64'sd288)), 48'sd0,
          48'((64'sd18*ONE+64'sd144)/64'sd288),
          48'(-((64'sd678*ONE+64'sd144)/64'sd288)),
          48'((64'sd456*ONE+64'sd144)/64'sd288),
          48'(-((64'sd9*ONE+64'sd144)/64'sd288)),
          48'((64'sd576*ONE+64'sd144)/64'sd288),
          48'((64'sd4*ONE+64'sd144)/64'sd288), 48'sd0, 48'sd0},
        '{48'((64'sd1481*ONE+64'sd410)/64'sd820), 48'sd0,
          48'(-((64'sd81*ONE+64'sd410)/64'sd820)),
          48'((64'sd7104*ONE+64'sd410)/64'sd820),
          48'(-((64'sd3376*ONE+64'sd410)/64'sd820)),
          48'((64'sd72*ONE+64'sd410)/64'sd820),
          48'(-((64'sd5040*ONE+64'sd410)/64'sd820)),
          48'(-((64'sd60*ONE+64'sd410)/64'sd820)),
          48'((64'sd720*ONE+64'sd410)/64'sd820), 48'sd0},
        '{48'((64'sd41*ONE+64'sd420)/64'sd840), 48'sd0, 48'sd0,
          48'((64'sd27*ONE+64'sd420)/64'sd840),
          48'((64'sd272*ONE+64'sd420)/64'sd840),
          48'((64'sd27*ONE+64'sd420)/64'sd840),
          48'((64'sd216*ONE+64'sd420)/64'sd840), 48'sd0,
          48'((64'sd216*ONE+64'sd420)/64'sd840),
          48'((64'sd41*ONE+64'sd420)/64'sd840)}
    };

    // Node offsets c (row sum over row denominator).
    localparam data_t COEF_C [NUM_ROWS] = '{
        48'((64'sd4*ONE+64'sd13)/64'sd27),
        48'((64'sd4*ONE+64'sd9)/64'sd18),
        48'((64'sd4*ONE+64'sd6)/64'sd12),
        48'((64'sd4*ONE+64'sd4)/64'sd8),
        48'((64'sd36*ONE+64'sd27)/64'sd54),
        48'((64'sd720*ONE+64'sd2160)/64'sd4320),
        48'((64'sd20*ONE+64'sd10)/64'sd20),
        48'((64'sd240*ONE+64'sd144)/64'sd288),
        48'((64'sd820*ONE+64'sd410)/64'sd820),
        48'((64'sd840*ONE+64'sd420)/64'sd840)
    };

    function automatic data_t sat48(input logic signed [ACC_W-1:0] v);
        data_t r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -64'sh0000_8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/rk8_ram.sv @@
// ----------------------------------------------------------------------------
// rk8_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rk8_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rk8_mul.sv @@
// ----------------------------------------------------------------------------
// rk8_mul
// Multi-cycle signed 48x48 fixed-point multiply with round and clamp.
// ----------------------------------------------------------------------------
module rk8_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  rk8_pkg::data_t                     a,
    input  rk8_pkg::data_t                     b,
    output logic                               done,
    output logic signed [rk8_pkg::PROD_W-1:0]  res
);

    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic [47:0] ma_reg;
    logic [47:0] mb_reg;
    logic        neg_reg;
    logic [95:0] acc_reg;
    logic signed [rk8_pkg::PROD_W-1:0] res_reg;

    logic [23:0] x;
    logic [23:0] y;
    logic [47:0] pp;
    logic [95:0] pp_sh;
    logic [95:0] rsum;
    logic [63:0] rl;
    logic [58:0] rl_c;

    always_comb
    begin
        x = (cnt_reg == 3'd2 || cnt_reg == 3'd3) ? ma_reg[47:24] : ma_reg[23:0];
        y = (cnt_reg == 3'd1 || cnt_reg == 3'd3) ? mb_reg[47:24] : mb_reg[23:0];
        pp = x * y;
        unique case (cnt_reg)
            3'd0:    pp_sh = {48'd0, pp};
            3'd3:    pp_sh = {pp, 48'd0};
            default: pp_sh = {24'd0, pp, 24'd0};
        endcase
        rsum = acc_reg + 96'h8000_0000;
        rl   = rsum[95:32];
        // magnitude clamp at 2^58
        rl_c = (rl > (64'd1 << 58)) ? {1'b1, 58'd0} : rl[58:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (go && !busy_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd5)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && !busy_reg)
        begin
            ma_reg  <= a[47] ? 48'(-a) : a;
            mb_reg  <= b[47] ? 48'(-b) : b;
            neg_reg <= a[47] ^ b[47];
            acc_reg <= 96'd0;
        end
        else if (busy_reg && cnt_reg < 3'd4)
            acc_reg <= acc_reg + pp_sh;
        else if (busy_reg && cnt_reg == 3'd4)
            res_reg <= neg_reg ? -$signed({1'b0, rl_c}) : $signed({1'b0, rl_c});
    end

    assign done = busy_reg && (cnt_reg == 3'd5);
    assign res  = res_reg;

endmodule

@@ rtl/core/rk8_dp.sv @@
// ----------------------------------------------------------------------------
// rk8_dp
// Datapath: config registers, stores, accumulator, step state, output word.
// ----------------------------------------------------------------------------
module rk8_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [rk8_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rk8_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 func,
    input  logic [rk8_pkg::ADDR_W-1:0]           elem_index,
    input  logic signed [rk8_pkg::DATA_W-1:0]    item_value,
    input  logic signed [rk8_pkg::DATA_W-1:0]    start_time,
    input  logic                                 eval_failed,
    input  logic                                 out_stall,
    input  rk8_pkg::cmd_t                        cmd,
    output rk8_pkg::sts_t                        sts,
    output logic                                 out_valid,
    output logic [rk8_pkg::STAGE_W-1:0]          out_stage,
    output logic [rk8_pkg::ADDR_W-1:0]           out_index,
    output logic signed [rk8_pkg::DATA_W-1:0]    eval_time,
    output logic signed [rk8_pkg::DATA_W-1:0]    out_value,
    output logic                                 last_element,
    output logic                                 error_seen
);

    rk8_pkg::data_t                  step_size_reg;
    logic [rk8_pkg::DIM_W-1:0]       dimension_reg;
    logic [rk8_pkg::STAGE_W-1:0]     stage_reg;
    rk8_pkg::data_t                  t0_reg;
    logic                            err_reg;

    logic [rk8_pkg::ADDR_W-1:0]      idx_reg;
    rk8_pkg::data_t                  val_reg;
    rk8_pkg::data_t                  st_reg;
    logic                            fail_reg;
    logic [rk8_pkg::STAGE_W-1:0]     j_reg;
    logic signed [rk8_pkg::ACC_W-1:0] acc_reg;
    rk8_pkg::data_t                  d_reg;

    logic                            out_valid_reg;
    logic [rk8_pkg::STAGE_W-1:0]     out_stage_reg;
    logic [rk8_pkg::ADDR_W-1:0]      out_index_reg;
    rk8_pkg::data_t                  eval_time_reg;
    rk8_pkg::data_t                  out_value_reg;
    logic                            last_reg;
    logic                            err_out_reg;

    logic [rk8_pkg::STAGE_W-1:0]     row;
    logic [rk8_pkg::DIM_W-1:0]       dim_eff;
    logic                            last_w;
    logic                            out_free;
    logic                            err_fin;
    logic [47:0]                     y0;
    logic [47:0]                     slope_rd;
    rk8_pkg::data_t                  mul_a;
    rk8_pkg::data_t                  mul_b;
    logic                            mul_done;
    logic signed [rk8_pkg::PROD_W-1:0] mul_res;
    logic signed [rk8_pkg::ACC_W-1:0]  mul_res_x;
    logic signed [rk8_pkg::ACC_W-1:0]  time_sum;
    logic signed [rk8_pkg::ACC_W-1:0]  val_sum;

    always_comb
    begin
        row = stage_reg - 4'd1;
        if (dimension_reg == 7'd0)
            dim_eff = 7'd1;
        else if (dimension_reg > 7'(rk8_pkg::MAX_DIM))
            dim_eff = 7'(rk8_pkg::MAX_DIM);
        else
            dim_eff = dimension_reg;
        last_w    = ({1'b0, idx_reg} == dim_eff - 7'd1);
        out_free  = !out_valid_reg || !out_stall;
        err_fin   = err_reg | fail_reg;
        mul_res_x = {{(rk8_pkg::ACC_W - rk8_pkg::PROD_W){mul_res[rk8_pkg::PROD_W-1]}},
                     mul_res};
        time_sum  = 64'(t0_reg) + 64'(rk8_pkg::sat48(mul_res_x));
        val_sum   = 64'($signed(y0)) + 64'(d_reg);
        unique case (cmd.mul_sel)
            rk8_pkg::MSEL_K:
            begin
                mul_a = rk8_pkg::COEF_K[row][j_reg];
                mul_b = (j_reg == row) ? val_reg : $signed(slope_rd);
            end
            rk8_pkg::MSEL_H:
            begin
                mul_a = step_size_reg;
                mul_b = rk8_pkg::sat48(acc_reg);
            end
            rk8_pkg::MSEL_T:
            begin
                mul_a = step_size_reg;
                mul_b = rk8_pkg::COEF_C[row];
            end
            default:
            begin
                mul_a = step_size_reg;
                mul_b = val_reg;
            end
        endcase
    end

    rk8_ram #(.WIDTH(rk8_pkg::DATA_W), .DEPTH(rk8_pkg::MAX_DIM)) u_start_ram (
        .clk   (clk),
        .we    (cmd.load_commit),
        .waddr (idx_reg),
        .wdata (val_reg),
        .re    (cmd.slope_issue),
        .raddr (idx_reg),
        .rdata (y0)
    );

    rk8_ram #(.WIDTH(rk8_pkg::DATA_W), .DEPTH(rk8_pkg::SLOPE_DEPTH)) u_slope_ram (
        .clk   (clk),
        .we    (cmd.slope_issue && (row <= rk8_pkg::ROW_LAST_STORED)),
        .waddr ({row, idx_reg}),
        .wdata (val_reg),
        .re    (cmd.rd_issue && (j_reg != row)),
        .raddr ({j_reg, idx_reg}),
        .rdata (slope_rd)
    );

    rk8_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= 48'sh0001_0000_0000;
            dimension_reg <= 7'd1;
            stage_reg     <= rk8_pkg::STAGE_FIRST;
            t0_reg        <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rk8_pkg::CFG_STEP_SIZE: step_size_reg <= cfg_data;
                    rk8_pkg::CFG_DIMENSION: dimension_reg <= cfg_data[rk8_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_commit)
            begin
                stage_reg <= rk8_pkg::STAGE_FIRST;
                if (idx_reg == '0)
                begin
                    t0_reg  <= st_reg;
                    err_reg <= 1'b0;
                end
            end
            if (cmd.fin_commit)
            begin
                err_reg <= err_fin;
                if (last_w)
                    stage_reg <= (stage_reg == rk8_pkg::STAGE_LAST) ?
                                 rk8_pkg::STAGE_FIRST : stage_reg + 4'd1;
            end
            if (cmd.load_commit || cmd.fin_commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= elem_index;
            val_reg  <= item_value;
            st_reg   <= start_time;
            fail_reg <= eval_failed;
        end
        if (cmd.slope_issue)
        begin
            acc_reg <= '0;
            j_reg   <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + mul_res_x;
            j_reg   <= j_reg + 4'd1;
        end
        if (cmd.take_d)
            d_reg <= rk8_pkg::sat48(mul_res_x);
        if (cmd.load_commit)
        begin
            out_stage_reg <= rk8_pkg::STAGE_FIRST;
            out_index_reg <= idx_reg;
            eval_time_reg <= (idx_reg == '0) ? st_reg : t0_reg;
            out_value_reg <= val_reg;
            last_reg      <= last_w;
            err_out_reg   <= (idx_reg == '0) ? 1'b0 : err_reg;
        end
        else if (cmd.fin_commit)
        begin
            out_stage_reg <= stage_reg + 4'd1;
            out_index_reg <= idx_reg;
            eval_time_reg <= rk8_pkg::sat48(time_sum);
            out_value_reg <= rk8_pkg::sat48(val_sum);
            last_reg      <= last_w;
            err_out_reg   <= err_fin;
        end
    end

    assign sts.in_load  = !func;
    assign sts.j_last   = (j_reg == row);
    assign sts.mul_done = mul_done;
    assign sts.out_free = out_free;

    assign out_valid    = out_valid_reg;
    assign out_stage    = out_stage_reg;
    assign out_index    = out_index_reg;
    assign eval_time    = eval_time_reg;
    assign out_value    = out_value_reg;
    assign last_element = last_reg;
    assign error_seen   = err_out_reg;

endmodule

@@ rtl/core/rk8_ctrl.sv @@
// ----------------------------------------------------------------------------
// rk8_ctrl
// Sequencer: walks the stage sum term by term and issues datapath commands.
// ----------------------------------------------------------------------------
module rk8_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  rk8_pkg::sts_t  sts,
    output rk8_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LOAD = 9'b000000010,
        ST_PREP = 9'b000000100,
        ST_RD   = 9'b000001000,
        ST_MK   = 9'b000010000,
        ST_ACC  = 9'b000100000,
        ST_MH   = 9'b001000000,
        ST_MT   = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = rk8_pkg::MSEL_K;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.in_load ? ST_LOAD : ST_PREP;
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                cmd.slope_issue = 1'b1;
                state_next      = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_MK;
            end
            ST_MK:
            begin
                cmd.mul_go = 1'b1;
                if (sts.mul_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = sts.j_last ? ST_MH : ST_RD;
            end
            ST_MH:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = rk8_pkg::MSEL_H;
                if (sts.mul_done)
                begin
                    cmd.take_d = 1'b1;
                    state_next = ST_MT;
                end
            end
            ST_MT:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = rk8_pkg::MSEL_T;
                if (sts.mul_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // product of h*c stays in the multiplier result register
                cmd.mul_sel = rk8_pkg::MSEL_T;
                if (sts.out_free)
                begin
                    cmd.fin_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/core/runge_kutta8_stage_combiner_unit.sv @@
// ----------------------------------------------------------------------------
// runge_kutta8_stage_combiner_unit
// Stage combiner of a 10-stage 8th-order Runge-Kutta step, Q15.32.
// ----------------------------------------------------------------------------
// One input word is handled at a time. A start-state load commits once the
// output register is free. For a derivative word, each tableau term takes a
// slope memory read (the term of the word's own stage uses the word itself),
// a pass through the one shared 24x24 partial-product multiplier and an
// accumulate step, followed by the h*sum and h*c products and the output
// commit, plus any wait for the output register. The output register lets
// the next word be taken while a result waits. Stores need no clearing after
// reset.
module runge_kutta8_stage_combiner_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rk8_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rk8_pkg::DATA_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [rk8_pkg::ADDR_W-1:0]         elem_index,
    input  logic signed [rk8_pkg::DATA_W-1:0]  item_value,
    input  logic signed [rk8_pkg::DATA_W-1:0]  start_time,
    input  logic                               eval_failed,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rk8_pkg::STAGE_W-1:0]        out_stage,
    output logic [rk8_pkg::ADDR_W-1:0]         out_index,
    output logic signed [rk8_pkg::DATA_W-1:0]  eval_time,
    output logic signed [rk8_pkg::DATA_W-1:0]  out_value,
    output logic                               last_element,
    output logic                               error_seen
);

    rk8_pkg::cmd_t cmd;
    rk8_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    rk8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rk8_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .elem_index   (elem_index),
        .item_value   (item_value),
        .start_time   (start_time),
        .eval_failed  (eval_failed),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stage    (out_stage),
        .out_index    (out_index),
        .eval_time    (eval_time),
        .out_value    (out_value),
        .last_element (last_element),
        .error_seen   (error_seen)
    );

endmodule

@@ rtl/core/rk8_chk.sv @@
// ----------------------------------------------------------------------------
// rk8_chk
// Port-level checks on the stage combiner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rk8_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [rk8_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [rk8_pkg::DATA_W-1:0]         cfg_data,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               func,
    input logic [rk8_pkg::ADDR_W-1:0]         elem_index,
    input logic signed [rk8_pkg::DATA_W-1:0]  item_value,
    input logic signed [rk8_pkg::DATA_W-1:0]  start_time,
    input logic                               eval_failed,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [rk8_pkg::STAGE_W-1:0]        out_stage,
    input logic [rk8_pkg::ADDR_W-1:0]         out_index,
    input logic signed [rk8_pkg::DATA_W-1:0]  eval_time,
    input logic signed [rk8_pkg::DATA_W-1:0]  out_value,
    input logic                               last_element,
    input logic                               error_seen
);

    // one word in flight: after a word is taken the input side holds off
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")

    `ASSERT_CLK(a_stage_range, clk, rst_n, out_valid |-> (out_stage >= 4'd1 && out_stage <= 4'd11), "out_stage out of range")

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled output word dropped")

    `ASSERT_CLK(a_cfg_ready, clk, rst_n, cfg_ready, "config port not ready")

endmodule

bind runge_kutta8_stage_combiner_unit rk8_chk u_chk (.*);
